[src/cpg_pkg.sv]
// Shared widths, codes, the job record and the mirror table for the circle point generator.
// Depends on nothing; every other file of the block uses it by scoped names.
package cpg_pkg;

    localparam int COORD_BITS  = 11;
    localparam int CIN_BITS    = 11;
    localparam int RADIUS_BITS = 10;
    localparam int STEP_BITS   = 11;
    localparam int DEC_BITS    = 16;
    localparam int POINT_BITS  = 12;
    localparam int SUM_BITS    = ((COORD_BITS > POINT_BITS) ? COORD_BITS : POINT_BITS) + 1;
    localparam int IDX_BITS    = 3;

    localparam logic [IDX_BITS-1:0] LAST_IDX_START = IDX_BITS'(3);
    localparam logic [IDX_BITS-1:0] LAST_IDX_STEP  = IDX_BITS'(7);

    localparam logic signed [DEC_BITS-1:0] DEC_INIT     = DEC_BITS'(3);
    localparam logic signed [DEC_BITS-1:0] DEC_INC_LOW  = DEC_BITS'(6);
    localparam logic signed [DEC_BITS-1:0] DEC_INC_HIGH = DEC_BITS'(10);
    localparam int                         DEC_GAIN_SHIFT = 2;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                         kind;
        logic signed [COORD_BITS-1:0]  cx;
        logic signed [COORD_BITS-1:0]  cy;
        logic signed [STEP_BITS-1:0]   x;
        logic signed [STEP_BITS-1:0]   y;
        logic [IDX_BITS-1:0]           last_idx;
        logic                          fin;
    } job_t;

    // swap: x offset comes from y and y offset from x; neg_a/neg_b negate those offsets.
    typedef struct packed {
        logic swap;
        logic neg_a;
        logic neg_b;
    } mirror_t;

    function automatic mirror_t mirror_sel(kind_t kind, logic [IDX_BITS-1:0] idx);
        mirror_t m;
        m = '0;
        if (kind == KIND_STEP) begin
            m.swap  = idx[2];
            m.neg_a = idx[0];
            m.neg_b = idx[1];
        end else begin
            case (idx)
                IDX_BITS'(0): m = '{swap: 1'b0, neg_a: 1'b0, neg_b: 1'b0};
                IDX_BITS'(1): m = '{swap: 1'b0, neg_a: 1'b0, neg_b: 1'b1};
                IDX_BITS'(2): m = '{swap: 1'b1, neg_a: 1'b0, neg_b: 1'b0};
                IDX_BITS'(3): m = '{swap: 1'b1, neg_a: 1'b1, neg_b: 1'b0};
                default:      m = '0;
            endcase
        end
        return m;
    endfunction

endpackage

[src/cpg_stepper.sv]
// Circle state and decision-variable update for the circle point generator.
// Depends on cpg_pkg; hands one job record per accepted transaction to the emitter.
module cpg_stepper (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  load,
    input  cpg_pkg::kind_t                        kind,
    input  logic [cpg_pkg::CIN_BITS-1:0]          center_x,
    input  logic [cpg_pkg::CIN_BITS-1:0]          center_y,
    input  logic [cpg_pkg::RADIUS_BITS-1:0]       radius,
    output cpg_pkg::job_t                         job,
    output logic                                  job_has_points
);

    logic signed [cpg_pkg::COORD_BITS-1:0] centre_x_reg, centre_x_next;
    logic signed [cpg_pkg::COORD_BITS-1:0] centre_y_reg, centre_y_next;
    logic signed [cpg_pkg::STEP_BITS-1:0]  step_x_reg, step_x_next;
    logic signed [cpg_pkg::STEP_BITS-1:0]  step_y_reg, step_y_next;
    logic signed [cpg_pkg::DEC_BITS-1:0]   decision_reg, decision_next;
    logic                                  active_reg, active_next;

    logic signed [cpg_pkg::COORD_BITS-1:0] cx_in, cy_in;
    logic signed [cpg_pkg::STEP_BITS-1:0]  r_step;
    logic signed [cpg_pkg::DEC_BITS-1:0]   dec_start, x_ext, y_ext, dec_step;
    logic signed [cpg_pkg::STEP_BITS-1:0]  x_adv, y_adv;
    logic                                  fin;

    // Centre fields are reinterpreted as COORD_BITS-wide two's complement values.
    always_comb begin
        for (int i = 0; i < cpg_pkg::COORD_BITS; i++) begin
            cx_in[i] = (i < cpg_pkg::CIN_BITS) ? center_x[i] : 1'b0;
            cy_in[i] = (i < cpg_pkg::CIN_BITS) ? center_y[i] : 1'b0;
        end
    end

    assign r_step    = cpg_pkg::STEP_BITS'(radius);
    assign dec_start = cpg_pkg::DEC_INIT - (cpg_pkg::DEC_BITS'(radius) <<< 1);
    assign x_ext     = {{(cpg_pkg::DEC_BITS-cpg_pkg::STEP_BITS){step_x_reg[cpg_pkg::STEP_BITS-1]}},
                        step_x_reg};
    assign y_ext     = {{(cpg_pkg::DEC_BITS-cpg_pkg::STEP_BITS){step_y_reg[cpg_pkg::STEP_BITS-1]}},
                        step_y_reg};

    always_comb begin
        if (decision_reg[cpg_pkg::DEC_BITS-1]) begin
            dec_step = decision_reg + (x_ext <<< cpg_pkg::DEC_GAIN_SHIFT) + cpg_pkg::DEC_INC_LOW;
            y_adv    = step_y_reg;
        end else begin
            dec_step = decision_reg + ((x_ext - y_ext) <<< cpg_pkg::DEC_GAIN_SHIFT)
                       + cpg_pkg::DEC_INC_HIGH;
            y_adv    = step_y_reg - cpg_pkg::STEP_BITS'(1);
        end
        x_adv = step_x_reg + cpg_pkg::STEP_BITS'(1);
        fin   = (x_adv > y_adv);
    end

    always_comb begin
        centre_x_next = centre_x_reg;
        centre_y_next = centre_y_reg;
        step_x_next   = step_x_reg;
        step_y_next   = step_y_reg;
        decision_next = decision_reg;
        active_next   = active_reg;
        if (kind == cpg_pkg::KIND_START) begin
            job.kind       = cpg_pkg::KIND_START;
            job.cx         = cx_in;
            job.cy         = cy_in;
            job.x          = '0;
            job.y          = r_step;
            job.last_idx   = cpg_pkg::LAST_IDX_START;
            job.fin        = 1'b0;
            job_has_points = 1'b1;
            if (load) begin
                centre_x_next = cx_in;
                centre_y_next = cy_in;
                step_x_next   = '0;
                step_y_next   = r_step;
                decision_next = dec_start;
                active_next   = 1'b1;
            end
        end else begin
            job.kind       = cpg_pkg::KIND_STEP;
            job.cx         = centre_x_reg;
            job.cy         = centre_y_reg;
            job.x          = x_adv;
            job.y          = y_adv;
            job.last_idx   = cpg_pkg::LAST_IDX_STEP;
            job.fin        = fin;
            job_has_points = active_reg;
            if (load && active_reg) begin
                step_x_next   = x_adv;
                step_y_next   = y_adv;
                decision_next = dec_step;
                active_next   = !fin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            step_x_reg   <= '0;
            step_y_reg   <= '0;
            decision_reg <= '0;
            active_reg   <= 1'b0;
        end else begin
            centre_x_reg <= centre_x_next;
            centre_y_reg <= centre_y_next;
            step_x_reg   <= step_x_next;
            step_y_reg   <= step_y_next;
            decision_reg <= decision_next;
            active_reg   <= active_next;
        end
    end

endmodule

[src/cpg_emitter.sv]
// Job register, point sequencer and output register of the circle point generator.
// Depends on cpg_pkg; produces one mirrored point per cycle from the held job while not stalled.
module cpg_emitter (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  load,
    input  cpg_pkg::job_t                         job_in,
    output logic                                  in_ready,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [cpg_pkg::POINT_BITS-1:0]        point_x,
    output logic [cpg_pkg::POINT_BITS-1:0]        point_y,
    output logic                                  last,
    output logic                                  finished
);

    cpg_pkg::job_t                   job_reg;
    logic                            job_valid_reg;
    logic [cpg_pkg::IDX_BITS-1:0]    idx_reg;
    logic                            out_valid_reg;
    logic [cpg_pkg::POINT_BITS-1:0]  point_x_reg, point_y_reg;
    logic                            last_reg, finished_reg;

    cpg_pkg::mirror_t                m;
    logic signed [cpg_pkg::STEP_BITS-1:0] a, b;
    logic signed [cpg_pkg::SUM_BITS-1:0]  a_ext, b_ext, dx, dy, px, py;
    logic                            emit, idx_last;

    assign emit     = job_valid_reg && (!out_valid_reg || out_ready);
    assign idx_last = (idx_reg == job_reg.last_idx);
    assign in_ready = !job_valid_reg || (emit && idx_last);

    always_comb begin
        m     = cpg_pkg::mirror_sel(job_reg.kind, idx_reg);
        a     = m.swap ? job_reg.y : job_reg.x;
        b     = m.swap ? job_reg.x : job_reg.y;
        a_ext = cpg_pkg::SUM_BITS'(a);
        b_ext = cpg_pkg::SUM_BITS'(b);
        dx    = m.neg_a ? -a_ext : a_ext;
        dy    = m.neg_b ? -b_ext : b_ext;
        px    = cpg_pkg::SUM_BITS'(job_reg.cx) + dx;
        py    = cpg_pkg::SUM_BITS'(job_reg.cy) + dy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (load) begin
                job_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end else if (emit) begin
                if (idx_last) begin
                    job_valid_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + cpg_pkg::IDX_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= job_in;
        end
        if (emit) begin
            point_x_reg  <= px[cpg_pkg::POINT_BITS-1:0];
            point_y_reg  <= py[cpg_pkg::POINT_BITS-1:0];
            last_reg     <= idx_last;
            finished_reg <= job_reg.fin;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign last      = last_reg;
    assign finished  = finished_reg;

endmodule

[src/circle_point_generator_top.sv]
// Bresenham circle rasterizer: a start gives 4 points, a step gives 8 or none.
// An item's job is held in the emitter's job register, its points in the output register;
// points leave one per cycle while the output is not stalled by m_tready.
// The next item is taken in the cycle the previous item's last point is registered.
// aresetn is synchronous, active low; clears circle state, job valid and output valid.
// Depends on cpg_pkg, cpg_stepper and cpg_emitter.
module circle_point_generator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // center_x[10:0], center_y[21:11], radius[31:22]
    input  logic [0:0]  s_tuser,   // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // point_x[11:0], point_y[23:12]
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // finished[0]
);

    cpg_pkg::job_t job;
    logic          job_has_points;
    logic          accept;
    logic [cpg_pkg::POINT_BITS-1:0] point_x, point_y;

    // A transaction is taken once the emitter can hold the job it produces.
    assign accept = s_tvalid && s_tready;

    // The stepper updates the circle state in the accept cycle and builds the job:
    // centre, current offsets, how many points and the finished flag.
    cpg_stepper u_stepper (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (accept),
        .kind           (cpg_pkg::kind_t'(s_tuser[0])),
        .center_x       (s_tdata[10:0]),
        .center_y       (s_tdata[21:11]),
        .radius         (s_tdata[31:22]),
        .job            (job),
        .job_has_points (job_has_points)
    );

    // The emitter walks the mirror table of the held job, one point per cycle,
    // into an output register that holds while the master side stalls.
    cpg_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept && job_has_points),
        .job_in    (job),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .point_x   (point_x),
        .point_y   (point_y),
        .last      (m_tlast),
        .finished  (m_tuser[0])
    );

    assign m_tdata = {point_y, point_x};

endmodule
